// ===== rtl/core/sid_pkg.sv =====
// ----------------------------------------------------------------------------
// sid_pkg
// Shared widths, register indexes and payload types of the 2D segment
// intersection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sid_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
   localparam int PROD_WIDTH     = 2 * DIFF_WIDTH;
   localparam int DET_WIDTH      = PROD_WIDTH + 1;
   localparam int NUM_LO_WIDTH   = (DET_WIDTH + 1) / 2;
   localparam int NUM_HI_WIDTH   = DET_WIDTH - NUM_LO_WIDTH;
   localparam int PART_WIDTH     = DIFF_WIDTH + DET_WIDTH;
   localparam int DIVIDEND_WIDTH = PART_WIDTH + 1;
   localparam int REM_WIDTH      = DET_WIDTH + 1;
   localparam int QUOT_WIDTH     = DIFF_WIDTH;
   localparam int DIV_LATENCY    = QUOT_WIDTH + 1;
   localparam int SQ_WIDTH       = 2 * (COORD_WIDTH + 1);
   localparam int NUM_LANES      = 4;

   localparam int TOL_WIDTH       = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DET_ZERO_TOL = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COH_TOL_SQ   = 1'd1;

   localparam logic [TOL_WIDTH-1:0] DET_ZERO_TOL_RESET = 32'd1;
   localparam logic [TOL_WIDTH-1:0] COH_TOL_SQ_RESET   = 32'd64;

   localparam int FIFO_DEPTH     = 2;
   localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_start_u;
      logic signed [COORD_WIDTH-1:0] a_start_v;
      logic signed [COORD_WIDTH-1:0] a_end_u;
      logic signed [COORD_WIDTH-1:0] a_end_v;
      logic signed [COORD_WIDTH-1:0] b_start_u;
      logic signed [COORD_WIDTH-1:0] b_start_v;
      logic signed [COORD_WIDTH-1:0] b_end_u;
      logic signed [COORD_WIDTH-1:0] b_end_v;
   } sid_req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [COORD_WIDTH-1:0] cross_u;
      logic signed [COORD_WIDTH-1:0] cross_v;
   } sid_rsp_type;

   // classified item handed from the front end to the back end
   typedef struct packed {
      logic                                   ok;
      logic [NUM_LANES-1:0][COORD_WIDTH-1:0]  start;  // asu, asv, bsu, bsv
      logic [NUM_LANES-1:0][DIFF_WIDTH-1:0]   dir;    // du, dv, eu, ev
      logic [DET_WIDTH-1:0]                   n1;
      logic [DET_WIDTH-1:0]                   n2;
      logic [DET_WIDTH-1:0]                   det;
   } sid_entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/sid_front.sv =====
// ----------------------------------------------------------------------------
// sid_front
// Front end: direction vectors, determinant and Cramer numerators, sign
// normalisation and the parallel / parameter range classification.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_front import sid_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire sid_req_type          in_req,
   input  wire logic [TOL_WIDTH-1:0] det_tol,
   output logic                      push,
   output sid_entry_type             entry
);

   typedef struct packed {
      logic [NUM_LANES-1:0][COORD_WIDTH-1:0] start;
      logic signed [DIFF_WIDTH-1:0]          du;
      logic signed [DIFF_WIDTH-1:0]          dv;
      logic signed [DIFF_WIDTH-1:0]          eu;
      logic signed [DIFF_WIDTH-1:0]          ev;
   } geo_type;

   logic v1_ff, v2_ff, v3_ff, v4_ff;

   geo_type geo1_in, geo1_ff, geo2_ff, geo3_ff, geo4_ff;
   logic signed [DIFF_WIDTH-1:0] fu_in, fv_in, fu1_ff, fv1_ff;
   logic signed [PROD_WIDTH-1:0] prod_in [0:5];
   logic signed [PROD_WIDTH-1:0] prod2_ff [0:5];
   logic signed [DET_WIDTH-1:0]  det3_in, n13_in, n23_in;
   logic signed [DET_WIDTH-1:0]  det3_ff, n13_ff, n23_ff;
   logic signed [DET_WIDTH-1:0]  det4_in, n14_in, n24_in;
   logic signed [DET_WIDTH-1:0]  det4_ff, n14_ff, n24_ff;
   logic                         ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage 1: differences
   always_comb begin
      geo1_in.start = {in_req.b_start_v, in_req.b_start_u,
                       in_req.a_start_v, in_req.a_start_u};
      geo1_in.du = {in_req.a_end_u[COORD_WIDTH-1], in_req.a_end_u}
                 - {in_req.a_start_u[COORD_WIDTH-1], in_req.a_start_u};
      geo1_in.dv = {in_req.a_end_v[COORD_WIDTH-1], in_req.a_end_v}
                 - {in_req.a_start_v[COORD_WIDTH-1], in_req.a_start_v};
      geo1_in.eu = {in_req.b_end_u[COORD_WIDTH-1], in_req.b_end_u}
                 - {in_req.b_start_u[COORD_WIDTH-1], in_req.b_start_u};
      geo1_in.ev = {in_req.b_end_v[COORD_WIDTH-1], in_req.b_end_v}
                 - {in_req.b_start_v[COORD_WIDTH-1], in_req.b_start_v};
      fu_in = {in_req.a_start_u[COORD_WIDTH-1], in_req.a_start_u}
            - {in_req.b_start_u[COORD_WIDTH-1], in_req.b_start_u};
      fv_in = {in_req.a_start_v[COORD_WIDTH-1], in_req.a_start_v}
            - {in_req.b_start_v[COORD_WIDTH-1], in_req.b_start_v};
   end

   // stage 2: six cross products
   always_comb begin
      prod_in[0] = geo1_ff.eu * geo1_ff.dv;
      prod_in[1] = geo1_ff.du * geo1_ff.ev;
      prod_in[2] = fu1_ff * geo1_ff.ev;
      prod_in[3] = geo1_ff.eu * fv1_ff;
      prod_in[4] = fu1_ff * geo1_ff.dv;
      prod_in[5] = geo1_ff.du * fv1_ff;
   end

   // stage 3: determinant and numerators
   always_comb begin
      det3_in = DET_WIDTH'(prod2_ff[0]) - DET_WIDTH'(prod2_ff[1]);
      n13_in  = DET_WIDTH'(prod2_ff[2]) - DET_WIDTH'(prod2_ff[3]);
      n23_in  = DET_WIDTH'(prod2_ff[4]) - DET_WIDTH'(prod2_ff[5]);
   end

   // stage 4: make the determinant non-negative
   always_comb begin
      if (det3_ff[DET_WIDTH-1]) begin
         det4_in = -det3_ff;
         n14_in  = -n13_ff;
         n24_in  = -n23_ff;
      end else begin
         det4_in = det3_ff;
         n14_in  = n13_ff;
         n24_in  = n23_ff;
      end
   end

   always_ff @(posedge clock) begin
      geo1_ff <= geo1_in;
      fu1_ff  <= fu_in;
      fv1_ff  <= fv_in;
      geo2_ff <= geo1_ff;
      for (int i = 0; i < 6; i++) begin
         prod2_ff[i] <= prod_in[i];
      end
      geo3_ff <= geo2_ff;
      det3_ff <= det3_in;
      n13_ff  <= n13_in;
      n23_ff  <= n23_in;
      geo4_ff <= geo3_ff;
      det4_ff <= det4_in;
      n14_ff  <= n14_in;
      n24_ff  <= n24_in;
   end

   // both parameters in [0,1], endpoints included
   assign ok = ($unsigned(det4_ff) > DET_WIDTH'(det_tol))
             && !n14_ff[DET_WIDTH-1] && (n14_ff <= det4_ff)
             && !n24_ff[DET_WIDTH-1] && (n24_ff <= det4_ff);

   always_comb begin
      entry.ok    = ok;
      entry.start = geo4_ff.start;
      entry.dir   = {geo4_ff.ev, geo4_ff.eu, geo4_ff.dv, geo4_ff.du};
      entry.n1    = n14_ff;
      entry.n2    = n24_ff;
      entry.det   = det4_ff;
   end

   assign push = v4_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sid_fifo.sv =====
// ----------------------------------------------------------------------------
// sid_fifo
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_fifo import sid_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire sid_entry_type push_entry,
   input  wire logic          pop,
   output logic               out_valid,
   output sid_entry_type      out_entry,
   output logic               full
);

   sid_entry_type mem [0:FIFO_DEPTH-1];

   logic [FIFO_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_WIDTH-1:0] count_ff, count_in;
   logic                      do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_WIDTH'(FIFO_DEPTH - 1)) ? '0
                   : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_WIDTH'(FIFO_DEPTH - 1)) ? '0
                   : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_entry = mem[rd_ptr_ff];
   assign full      = (count_ff == FIFO_CNT_WIDTH'(FIFO_DEPTH));

endmodule

`default_nettype wire

// ===== rtl/core/sid_div.sv =====
// ----------------------------------------------------------------------------
// sid_div
// Pipelined restoring divider, one quotient bit per stage, rounding to
// nearest with ties away from zero: (2*part + det) / (2*det).
// ----------------------------------------------------------------------------
`default_nettype none

module sid_div import sid_pkg::*; (
   input  wire logic                  clock,
   input  wire logic [PART_WIDTH-1:0] part,
   input  wire logic [DET_WIDTH-1:0]  det,
   output logic [QUOT_WIDTH-1:0]      quot
);

   logic [DIVIDEND_WIDTH-1:0] num_in;
   logic [REM_WIDTH-1:0]      rem_ff [0:QUOT_WIDTH-1];
   logic [REM_WIDTH-1:0]      div_ff [0:QUOT_WIDTH-1];
   logic [QUOT_WIDTH-1:0]     low_ff [0:QUOT_WIDTH];

   assign num_in = {part, 1'b0} + DIVIDEND_WIDTH'(det);

   // quotient fits QUOT_WIDTH bits, so the top part is already below the divisor
   always_ff @(posedge clock) begin
      rem_ff[0] <= num_in[DIVIDEND_WIDTH-1:QUOT_WIDTH];
      low_ff[0] <= num_in[QUOT_WIDTH-1:0];
      div_ff[0] <= {det, 1'b0};
   end

   for (genvar k = 0; k < QUOT_WIDTH; k++) begin : g_stage
      logic [REM_WIDTH:0]    trial;
      logic [REM_WIDTH:0]    diff;
      logic                  ge;
      logic [QUOT_WIDTH-1:0] low_in;

      assign trial  = {rem_ff[k], low_ff[k][QUOT_WIDTH-1]};
      assign diff   = trial - {1'b0, div_ff[k]};
      assign ge     = (trial >= {1'b0, div_ff[k]});
      // remaining dividend bits shift out while quotient bits shift in
      assign low_in = {low_ff[k][QUOT_WIDTH-2:0], ge};

      always_ff @(posedge clock) begin
         low_ff[k+1] <= low_in;
      end

      if (k < QUOT_WIDTH - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= ge ? diff[REM_WIDTH-1:0] : trial[REM_WIDTH-1:0];
            div_ff[k+1] <= div_ff[k];
         end
      end
   end

   assign quot = low_ff[QUOT_WIDTH];

endmodule

`default_nettype wire

// ===== rtl/core/sid_back.sv =====
// ----------------------------------------------------------------------------
// sid_back
// Back end: scaled parameters, both crossing points, coherence check and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_back import sid_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire sid_entry_type        entry,
   input  wire logic [TOL_WIDTH-1:0] coh_tol,
   output logic                      rsp_strobe,
   output sid_rsp_type               rsp_data
);

   typedef struct packed {
      logic                                  ok;
      logic [NUM_LANES-1:0]                  neg;
      logic [NUM_LANES-1:0][COORD_WIDTH-1:0] start;
   } side_type;

   localparam int SUM_WIDTH = DIFF_WIDTH + 1;

   logic v1_ff, v2_ff, v5_ff, v6_ff, v7_ff, v8_ff, out_v_ff;
   logic [DIV_LATENCY:0] vd_ff;

   side_type side1_in, side1_ff, side2_ff, side5_ff;
   side_type sd_ff [0:DIV_LATENCY];

   logic [NUM_LANES-1:0][DIFF_WIDTH-1:0] mag_in, mag1_ff;
   logic [1:0][DET_WIDTH-1:0]            num1_ff;
   logic [DET_WIDTH-1:0]                 det1_ff, det2_ff, det3_ff;

   logic [NUM_LANES-1:0][DIFF_WIDTH+NUM_LO_WIDTH-1:0] lo_in, lo2_ff;
   logic [NUM_LANES-1:0][DIFF_WIDTH+NUM_HI_WIDTH-1:0] hi_in, hi2_ff;
   logic [NUM_LANES-1:0][PART_WIDTH-1:0]              part_in, part3_ff;
   logic [NUM_LANES-1:0][QUOT_WIDTH-1:0]              quot;
   logic [NUM_LANES-1:0][SUM_WIDTH-1:0]               sq_in, sq5_ff;
   logic [NUM_LANES-1:0][COORD_WIDTH-1:0]             pt_in, pt6_ff;
   logic [NUM_LANES-1:0][SUM_WIDTH-1:0]               pt_sum;

   logic ok6_ff, ok7_ff, ok8_ff;
   logic signed [COORD_WIDTH:0]   dx_in, dy_in, dx7_ff, dy7_ff;
   logic [COORD_WIDTH-1:0]        pu7_ff, pv7_ff, pu8_ff, pv8_ff;
   logic signed [SQ_WIDTH-1:0]    sqx_in, sqy_in, sqx8_ff, sqy8_ff;
   logic [SQ_WIDTH:0]             sq_dist;
   logic                          hit_in;
   sid_rsp_type                   rsp_in, rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         vd_ff    <= '0;
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         v7_ff    <= 1'b0;
         v8_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         vd_ff    <= {vd_ff[DIV_LATENCY-1:0], v2_ff};
         v5_ff    <= vd_ff[DIV_LATENCY];
         v6_ff    <= v5_ff;
         v7_ff    <= v6_ff;
         v8_ff    <= v7_ff;
         out_v_ff <= v8_ff;
      end
   end

   // stage 1: magnitudes of the direction components
   always_comb begin
      side1_in.ok    = entry.ok;
      side1_in.start = entry.start;
      for (int l = 0; l < NUM_LANES; l++) begin
         side1_in.neg[l] = entry.dir[l][DIFF_WIDTH-1];
         mag_in[l] = entry.dir[l][DIFF_WIDTH-1] ? (~entry.dir[l] + 1'b1) : entry.dir[l];
      end
   end

   // stage 2: split products, A lanes use n1, B lanes n2
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         lo_in[l] = mag1_ff[l] * num1_ff[l >> 1][NUM_LO_WIDTH-1:0];
         hi_in[l] = mag1_ff[l] * num1_ff[l >> 1][DET_WIDTH-1:NUM_LO_WIDTH];
      end
   end

   // stage 3: recombine
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         part_in[l] = PART_WIDTH'(lo2_ff[l])
                    + (PART_WIDTH'(hi2_ff[l]) << NUM_LO_WIDTH);
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      sid_div u_div (
         .clock (clock),
         .part  (part3_ff[l]),
         .det   (det3_ff),
         .quot  (quot[l])
      );
   end

   // after the divider: restore sign, then offset by the start point
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         sq_in[l] = sd_ff[DIV_LATENCY].neg[l] ? (~{1'b0, quot[l]} + 1'b1)
                                              : {1'b0, quot[l]};
         pt_sum[l] = {{2{side5_ff.start[l][COORD_WIDTH-1]}}, side5_ff.start[l]}
                   + sq5_ff[l];
         pt_in[l]  = pt_sum[l][COORD_WIDTH-1:0];
      end
   end

   always_comb begin
      dx_in  = {pt6_ff[0][COORD_WIDTH-1], pt6_ff[0]} - {pt6_ff[2][COORD_WIDTH-1], pt6_ff[2]};
      dy_in  = {pt6_ff[1][COORD_WIDTH-1], pt6_ff[1]} - {pt6_ff[3][COORD_WIDTH-1], pt6_ff[3]};
      sqx_in = dx7_ff * dx7_ff;
      sqy_in = dy7_ff * dy7_ff;
      sq_dist = {1'b0, sqx8_ff} + {1'b0, sqy8_ff};
      hit_in = ok8_ff && !(sq_dist > (SQ_WIDTH + 1)'(coh_tol));
      rsp_in.hit     = hit_in;
      rsp_in.cross_u = hit_in ? pu8_ff : '0;
      rsp_in.cross_v = hit_in ? pv8_ff : '0;
   end

   always_ff @(posedge clock) begin
      side1_ff <= side1_in;
      mag1_ff  <= mag_in;
      num1_ff  <= {entry.n2, entry.n1};
      det1_ff  <= entry.det;
      side2_ff <= side1_ff;
      lo2_ff   <= lo_in;
      hi2_ff   <= hi_in;
      det2_ff  <= det1_ff;
      sd_ff[0] <= side2_ff;
      part3_ff <= part_in;
      det3_ff  <= det2_ff;
      for (int k = 1; k <= DIV_LATENCY; k++) begin
         sd_ff[k] <= sd_ff[k-1];
      end
      side5_ff <= sd_ff[DIV_LATENCY];
      sq5_ff   <= sq_in;
      ok6_ff   <= side5_ff.ok;
      pt6_ff   <= pt_in;
      ok7_ff   <= ok6_ff;
      dx7_ff   <= dx_in;
      dy7_ff   <= dy_in;
      pu7_ff   <= pt6_ff[0];
      pv7_ff   <= pt6_ff[1];
      ok8_ff   <= ok7_ff;
      sqx8_ff  <= sqx_in;
      sqy8_ff  <= sqy_in;
      pu8_ff   <= pu7_ff;
      pv8_ff   <= pv7_ff;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = out_v_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/segment_intersection_2d.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_2d
// 2D segment crossing test on signed Q16.16 endpoints with configurable
// parallel and coherence tolerances.
// Path: the result strobe follows the accepting edge through the front end, queue
//   and back end; the divider's one-quotient-bit-per-stage pipeline is most of it.
// Throughput: one item per cycle; busy stays low as the back end drains the
//   queue every cycle and the receiver cannot stall.
// Reset: synchronous; clears all valid bits and the queue, tolerances go to 1 and 64.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_2d import sid_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire sid_req_type                req_data,
   output logic                            rsp_strobe,
   output sid_rsp_type                     rsp_data,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [TOL_WIDTH-1:0] det_tol_ff, det_tol_in;
   logic [TOL_WIDTH-1:0] coh_tol_ff, coh_tol_in;

   logic          accept;
   logic          push;
   sid_entry_type push_entry;
   logic          q_valid;
   sid_entry_type q_entry;
   logic          q_full;

   always_comb begin
      det_tol_in = det_tol_ff;
      coh_tol_in = coh_tol_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DET_ZERO_TOL: det_tol_in = csr_wdata[TOL_WIDTH-1:0];
            REG_COH_TOL_SQ:   coh_tol_in = csr_wdata[TOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         det_tol_ff <= DET_ZERO_TOL_RESET;
         coh_tol_ff <= COH_TOL_SQ_RESET;
      end else begin
         det_tol_ff <= det_tol_in;
         coh_tol_ff <= coh_tol_in;
      end
   end

   assign accept = start && !busy;
   assign busy   = q_full;

   sid_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_req   (req_data),
      .det_tol  (det_tol_ff),
      .push     (push),
      .entry    (push_entry)
   );

   sid_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_valid),
      .out_valid  (q_valid),
      .out_entry  (q_entry),
      .full       (q_full)
   );

   sid_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .entry      (q_entry),
      .coh_tol    (coh_tol_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("queue filled up although the back end drains it");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.hit |-> (rsp_data.cross_u == '0) && (rsp_data.cross_v == '0))
      else $error("miss transfer carries a non-zero point");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == REG_DET_ZERO_TOL) |=>
         det_tol_ff == $past(csr_wdata[TOL_WIDTH-1:0]))
      else $error("tolerance write lost");
`endif

endmodule

`default_nettype wire
